/* rtl/btrf_pkg.sv */
// Shared types, constants and helper functions for the background tile row fetch block.
// No dependencies; every other file uses these names scoped through btrf_pkg::.
package btrf_pkg;

    // Video memory geometry
    localparam int VRAM_BYTES = 8192;
    localparam int VRAM_AW    = 13;
    localparam int MAP_TILES  = 32;
    localparam int MAP_AW     = $clog2(MAP_TILES);

    // Configuration register indexes
    localparam logic [2:0] CFG_SCROLL_X      = 3'd0;
    localparam logic [2:0] CFG_SCROLL_Y      = 3'd1;
    localparam logic [2:0] CFG_MAP_SELECT    = 3'd2;
    localparam logic [2:0] CFG_TILE_UNSIGNED = 3'd3;
    localparam logic [2:0] CFG_BG_PALETTE    = 3'd4;

    // Request opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // Map base high bits: 0x1800 -> 2'b11 followed by the select bit
    localparam logic [1:0] MAP_BASE_TOP = 2'b11;

    typedef struct packed {
        logic [7:0] scroll_x;
        logic [7:0] scroll_y;
        logic       map_select_high;
        logic       tile_data_unsigned;
        logic [7:0] bg_palette;
    } t_cfg;

    typedef struct packed {
        logic               op;
        logic [VRAM_AW-1:0] vram_addr;
        logic [7:0]         write_data;
        logic [7:0]         screen_line;
        logic [4:0]         tile_column;
    } t_in_item;

    typedef struct packed {
        logic [7:0] line_out;
        logic [4:0] column_out;
        logic [1:0] shade0;
        logic [1:0] shade1;
        logic [1:0] shade2;
        logic [1:0] shade3;
        logic [1:0] shade4;
        logic [1:0] shade5;
        logic [1:0] shade6;
        logic [1:0] shade7;
    } t_out_item;

    // Classified job handed from front to back
    typedef struct packed {
        logic               is_render;
        logic [VRAM_AW-1:0] addr;      // write address or map entry address
        logic [7:0]         data;
        logic [7:0]         line;
        logic [4:0]         column;
        logic [2:0]         row;       // tile row within the tile
    } t_job;

    // Tile data row address: low-plane byte of the given row
    function automatic logic [VRAM_AW-1:0] tile_row_addr(input logic [7:0] id,
                                                         input logic       unsigned_mode,
                                                         input logic [2:0] row);
        logic [VRAM_AW-1:0] base;
        if (unsigned_mode) begin
            base = {1'b0, id, 4'b0000};
        end else begin
            // ids 0..127 from 0x1000, ids 128..255 from 0x0800
            base = {~id[7], id[7], id[6:0], 4'b0000};
        end
        return base | {{(VRAM_AW-4){1'b0}}, row, 1'b0};
    endfunction

    // Palette lookup for one 2-bit color number
    function automatic logic [1:0] shade_of(input logic [7:0] pal, input logic [1:0] color);
        logic [1:0] s;
        unique case (color)
            2'd0:    s = pal[1:0];
            2'd1:    s = pal[3:2];
            2'd2:    s = pal[5:4];
            default: s = pal[7:6];
        endcase
        return s;
    endfunction

endpackage

/* rtl/btrf_front.sv */
// Front end: accepts requests, classifies write vs render, forms the map entry address.
// Depends on btrf_pkg; feeds btrf_queue.
module btrf_front (
    input  logic              i_start,
    input  btrf_pkg::t_in_item i_req,
    input  btrf_pkg::t_cfg     i_cfg,
    input  logic              i_full,
    output logic              o_busy,
    output logic              o_push,
    output btrf_pkg::t_job     o_job
);

    logic [7:0]                   v;
    logic [btrf_pkg::MAP_AW-1:0]  map_x;

    // Busy while the queue has no room
    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    // Vertical position wraps at 256, map column wraps at the map width
    assign v     = i_req.screen_line + i_cfg.scroll_y;
    assign map_x = btrf_pkg::MAP_AW'(i_req.tile_column)
                 + btrf_pkg::MAP_AW'(i_cfg.scroll_x[7:3]);

    always_comb begin
        o_job.is_render = (i_req.op == btrf_pkg::OP_RENDER);
        o_job.data      = i_req.write_data;
        o_job.line      = i_req.screen_line;
        o_job.column    = i_req.tile_column;
        o_job.row       = v[2:0];
        if (i_req.op == btrf_pkg::OP_RENDER) begin
            o_job.addr = {btrf_pkg::MAP_BASE_TOP, i_cfg.map_select_high, v[7:3], map_x};
        end else begin
            o_job.addr = i_req.vram_addr;
        end
    end

endmodule

/* rtl/btrf_queue.sv */
// Small FIFO of classified jobs between front and back end.
// Depends on btrf_pkg for the job type.
module btrf_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  btrf_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_empty,
    output logic           o_full,
    output btrf_pkg::t_job o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    btrf_pkg::t_job r_slot [0:DEPTH-1];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_head  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/btrf_back.sv */
// Back end: owns the video memory and runs the map / low plane / high plane read sequence.
// Depends on btrf_pkg; pulls jobs from btrf_queue.
module btrf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  btrf_pkg::t_cfg      i_cfg,
    input  logic                i_empty,
    input  btrf_pkg::t_job      i_head,
    output logic                o_pop,
    output logic                o_done,
    output btrf_pkg::t_out_item o_result
);

    typedef enum logic [1:0] {S_IDLE, S_MAP, S_LO, S_HI} t_state;

    t_state                        r_state;
    logic [7:0]                    r_vram [0:btrf_pkg::VRAM_BYTES-1];
    logic [7:0]                    r_rdata;
    logic [7:0]                    r_lo;
    logic [7:0]                    r_line;
    logic [4:0]                    r_column;
    logic [2:0]                    r_row;
    logic [btrf_pkg::VRAM_AW-1:0]  r_row_addr;
    logic                          r_done;
    btrf_pkg::t_out_item           r_result;

    logic [btrf_pkg::VRAM_AW-1:0]  mem_addr;
    logic                          mem_we;
    logic [btrf_pkg::VRAM_AW-1:0]  tile_addr;
    logic [1:0]                    shade [0:7];

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_done   = r_done;
    assign o_result = r_result;

    // Tile data address from the fetched map entry
    assign tile_addr = btrf_pkg::tile_row_addr(r_rdata, i_cfg.tile_data_unsigned, r_row);

    // Memory port select
    always_comb begin
        mem_we   = 1'b0;
        mem_addr = i_head.addr;
        unique case (r_state)
            S_IDLE: begin
                mem_we   = !i_empty && !i_head.is_render;
                mem_addr = i_head.addr;
            end
            S_MAP:   mem_addr = tile_addr;
            S_LO:    mem_addr = r_row_addr | btrf_pkg::VRAM_AW'(1);
            default: mem_addr = r_row_addr;
        endcase
    end

    // Single-port video memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_vram[mem_addr] <= i_head.data;
        end
        r_rdata <= r_vram[mem_addr];
    end

    // Pixel colors: high plane gives bit 1, low plane bit 0, MSB leftmost
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            shade[j] = btrf_pkg::shade_of(i_cfg.bg_palette,
                                          {r_rdata[7-j], r_lo[7-j]});
        end
    end

    // Sequencer and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty && i_head.is_render) begin
                        r_line   <= i_head.line;
                        r_column <= i_head.column;
                        r_row    <= i_head.row;
                        r_state  <= S_MAP;
                    end
                end
                S_MAP: begin
                    r_row_addr <= tile_addr;
                    r_state    <= S_LO;
                end
                S_LO: begin
                    r_lo    <= r_rdata;
                    r_state <= S_HI;
                end
                default: begin
                    r_result.line_out   <= r_line;
                    r_result.column_out <= r_column;
                    r_result.shade0     <= shade[0];
                    r_result.shade1     <= shade[1];
                    r_result.shade2     <= shade[2];
                    r_result.shade3     <= shade[3];
                    r_result.shade4     <= shade[4];
                    r_result.shade5     <= shade[5];
                    r_result.shade6     <= shade[6];
                    r_result.shade7     <= shade[7];
                    r_done              <= 1'b1;
                    r_state             <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/background_tile_row_fetch_top.sv */
// Top level of the background tile row fetch block: configuration registers and wiring.
// Depends on btrf_pkg, btrf_front, btrf_queue and btrf_back.
//
// Usage:
//   Requests enter on i_req, accepted at a clock edge with i_start high and o_busy low.
//   op = write stores write_data at vram_addr; op = render fetches one tile row of
//   the background for screen_line / tile_column and returns eight palette shades.
//   A result is shown on o_result for one cycle with o_done high; it cannot be held.
//   Configuration registers (scroll_x, scroll_y, map_select_high, tile_data_unsigned,
//   bg_palette at indexes 0..4, other indexes ignored) use i_cfg_valid / o_cfg_ready.
//   The user must put writes in between requests while the block is idle (unenforced).
// Timing:
//   A write occupies the video memory port while the sequencer is idle. A render uses the
//   single memory port for the map entry, low plane and high plane reads in turn, then
//   registers the shaded result. A new render or write starts only once the sequencer
//   is back in idle; the three dependent reads through the one memory port set this.
//   The front end queues up to QUEUE_DEPTH requests; o_busy is high while it is full.
// Reset: synchronous active-low i_rst_n clears the queue, sequencer and configuration;
//   video memory content is undefined until written.
module background_tile_row_fetch_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  btrf_pkg::t_in_item  i_req,
    output logic                o_done,
    output btrf_pkg::t_out_item o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);

    btrf_pkg::t_cfg r_cfg;
    btrf_pkg::t_job front_job, head_job;
    logic           push, pop, q_empty, q_full;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                btrf_pkg::CFG_SCROLL_X:      r_cfg.scroll_x           <= i_cfg_data;
                btrf_pkg::CFG_SCROLL_Y:      r_cfg.scroll_y           <= i_cfg_data;
                btrf_pkg::CFG_MAP_SELECT:    r_cfg.map_select_high    <= i_cfg_data[0];
                btrf_pkg::CFG_TILE_UNSIGNED: r_cfg.tile_data_unsigned <= i_cfg_data[0];
                btrf_pkg::CFG_BG_PALETTE:    r_cfg.bg_palette         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    btrf_front u_front (
        .i_start (i_start),
        .i_req   (i_req),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_busy  (o_busy),
        .o_push  (push),
        .o_job   (front_job)
    );

    btrf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_head  (head_job)
    );

    btrf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (q_empty),
        .i_head   (head_job),
        .o_pop    (pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
